// ===== rtl/spsel_pkg.sv =====
package spsel_pkg;

   localparam int CMD_W    = 2;
   localparam int SAMPLE_W = 32;
   localparam int PCT_W    = 14;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 9;

   localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PCT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MED = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   localparam logic [PCT_W-1:0] PCT_FULL_SCALE = 14'd10000;

   // floor(x / 10000) as (x * PCT_RECIP) >> PCT_RECIP_SHIFT, exact for x below 2**27
   localparam int                     PCT_RECIP_W     = 27;
   localparam int                     PCT_RECIP_SHIFT = 40;
   localparam logic [PCT_RECIP_W-1:0] PCT_RECIP       = 27'd109951163;

   // read address sources
   localparam logic [1:0] RA_TOP  = 2'd0;
   localparam logic [1:0] RA_MID  = 2'd1;
   localparam logic [1:0] RA_NEXT = 2'd2;
   localparam logic [1:0] RA_QUOT = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       keep;
      logic [PCT_W-1:0]           percent;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result_value;
      logic [STATUS_W-1:0]        status;
      logic [HELD_W-1:0]          held_count;
   } rsp_type;

   typedef struct packed {
      logic                latch;
      logic                pos_load;
      logic                pos_dec;
      logic                wr_en;
      logic                wr_sel_data;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                cnt_inc;
      logic                cnt_clear;
      logic                prod_load;
      logic                div_step;
      logic                rsp_load;
      logic                rsp_use_data;
      logic [STATUS_W-1:0] rsp_status;
   } ctl_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic is_greater;
      logic pos_last;
   } sts_type;

endpackage

// ===== rtl/spsel_ram.sv =====
module spsel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spsel_dp.sv =====
module spsel_dp #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  spsel_pkg::req_type req,
   input  spsel_pkg::ctl_type ctl,
   output spsel_pkg::sts_type sts,
   output logic               rsp_strobe,
   output spsel_pkg::rsp_type rsp
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PROD_W = CNT_W + spsel_pkg::PCT_W;
   localparam int MUL_W  = PROD_W + spsel_pkg::PCT_RECIP_W;

   logic [CNT_W-1:0]                     count_ff, count_in;
   logic [CNT_W-1:0]                     pos_ff, pos_in;
   logic signed [spsel_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [PROD_W-1:0]                    quot_ff, quot_in;
   spsel_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                 rsp_strobe_ff;

   logic [CNT_W-1:0]                     cnt_m1;
   logic [CNT_W-1:0]                     cnt_half;
   logic [CNT_W-1:0]                     pos_m2;
   logic [MUL_W-1:0]                     recip_prod;
   logic [AW-1:0]                        rd_addr;
   logic signed [spsel_pkg::SAMPLE_W-1:0] rd_data;
   logic [spsel_pkg::SAMPLE_W-1:0]       wr_data;

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_half = count_ff >> 1;
   assign pos_m2   = pos_ff - CNT_W'(2);

   always_comb begin
      case (ctl.rd_sel)
         spsel_pkg::RA_TOP:  rd_addr = cnt_m1[AW-1:0];
         spsel_pkg::RA_MID:  rd_addr = cnt_half[AW-1:0];
         spsel_pkg::RA_NEXT: rd_addr = pos_m2[AW-1:0];
         default:            rd_addr = quot_ff[AW-1:0];
      endcase
   end

   assign wr_data = ctl.wr_sel_data ? rd_data : sample_ff;

   spsel_ram #(
      .WIDTH (spsel_pkg::SAMPLE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // divide the rank product by the full scale through its reciprocal
   assign recip_prod = MUL_W'(quot_ff) * MUL_W'(spsel_pkg::PCT_RECIP);

   always_comb begin
      if (ctl.prod_load) begin
         quot_in = PROD_W'(cnt_m1) * PROD_W'(req.percent);
      end else begin
         quot_in = PROD_W'(recip_prod >> spsel_pkg::PCT_RECIP_SHIFT);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.cnt_clear) begin
         count_in = '0;
      end else if (ctl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      pos_in = pos_ff;
      if (ctl.pos_load) begin
         pos_in = count_ff;
      end else if (ctl.pos_dec) begin
         pos_in = pos_ff - CNT_W'(1);
      end
      sample_in = ctl.latch ? req.sample : sample_ff;
      rsp_in.result_value = ctl.rsp_use_data ? rd_data : '0;
      rsp_in.status       = ctl.rsp_status;
      rsp_in.held_count   = spsel_pkg::HELD_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= ctl.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      sample_ff <= sample_in;
      if (ctl.prod_load || ctl.div_step) begin
         quot_ff <= quot_in;
      end
      if (ctl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff >= CNT_W'(CAPACITY));
   assign sts.is_greater = (rd_data > sample_ff);
   assign sts.pos_last   = (pos_ff == CNT_W'(1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== rtl/spsel_ctrl.sv =====
module spsel_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  spsel_pkg::req_type req,
   input  spsel_pkg::sts_type sts,
   output spsel_pkg::ctl_type ctl,
   output logic               busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_FETCH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               unique case (req.cmd)
                  spsel_pkg::CMD_ADD: begin
                     if (!req.keep) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = spsel_pkg::ST_OK;
                     end else if (sts.count_full) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = spsel_pkg::ST_FULL;
                     end else begin
                        ctl.pos_load = 1'b1;
                        if (sts.count_zero) begin
                           state_in = S_PLACE;
                        end else begin
                           ctl.rd_en  = 1'b1;
                           ctl.rd_sel = spsel_pkg::RA_TOP;
                           state_in   = S_SHIFT;
                        end
                     end
                  end
                  spsel_pkg::CMD_PCT: begin
                     if (sts.count_zero) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = spsel_pkg::ST_EMPTY;
                     end else if (req.percent > spsel_pkg::PCT_FULL_SCALE) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = spsel_pkg::ST_RANGE;
                     end else begin
                        ctl.prod_load = 1'b1;
                        state_in      = S_DIV;
                     end
                  end
                  spsel_pkg::CMD_MED: begin
                     if (sts.count_zero) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = spsel_pkg::ST_EMPTY;
                     end else begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = spsel_pkg::RA_MID;
                        state_in   = S_FETCH;
                     end
                  end
                  default: begin
                     ctl.cnt_clear  = 1'b1;
                     ctl.rsp_load   = 1'b1;
                     ctl.rsp_status = spsel_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            ctl.wr_en = 1'b1;
            if (sts.is_greater) begin
               // move the larger entry up one slot
               ctl.wr_sel_data = 1'b1;
               ctl.pos_dec     = 1'b1;
               if (sts.pos_last) begin
                  state_in = S_PLACE;
               end else begin
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = spsel_pkg::RA_NEXT;
               end
            end else begin
               ctl.cnt_inc    = 1'b1;
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = spsel_pkg::ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_PLACE: begin
            ctl.wr_en      = 1'b1;
            ctl.cnt_inc    = 1'b1;
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = spsel_pkg::ST_OK;
            state_in       = S_IDLE;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = spsel_pkg::RA_QUOT;
            state_in   = S_FETCH;
         end
         S_FETCH: begin
            ctl.rsp_load     = 1'b1;
            ctl.rsp_use_data = 1'b1;
            ctl.rsp_status   = spsel_pkg::ST_OK;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/sorted_percentile_selector.sv =====
// Channel    Ports                        Handshake
// request    start, busy, req_data        taken when start high and busy low
// response   rsp_strobe, rsp_data         shown one cycle, always taken
//
// Cycles: clear, ignored and flagged items answer the cycle after they are taken.
// An insert shifts one entry per cycle from the top. A median reads the store
// and answers; a percentile forms the product, does the reciprocal multiply for
// the divide by 10000, reads the store and answers.
// Reset is synchronous and clears the count and the control, not the store.
// The response side cannot stall.
module sorted_percentile_selector #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  spsel_pkg::req_type req_data,
   output logic               rsp_strobe,
   output spsel_pkg::rsp_type rsp_data
);

   spsel_pkg::ctl_type ctl;
   spsel_pkg::sts_type sts;

   spsel_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_data),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   spsel_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int CAPACITY   = 256;
   localparam int WORD_GOAL  = 1750;
   localparam int TAIL_WORDS = 200;

   // one pending request word with its lead-in idle and drain hold
   typedef struct packed {
      spsel_pkg::req_type req;
      logic [2:0]         gap;
      logic               drain;
   } word_slot_type;

   logic               clock;
   logic               reset    = 1'b1;
   logic               start    = 1'b0;
   spsel_pkg::req_type req_data = '0;
   logic               busy;
   logic               rsp_strobe;
   spsel_pkg::rsp_type rsp_data;

   sorted_percentile_selector #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   word_slot_type      word_q[$];
   spsel_pkg::rsp_type answer_q[$];

   // predicted contents of the sorted store
   int sorted_vals[CAPACITY];
   int held_n = 0;

   int fail_count   = 0;
   int words_in     = 0;
   int results_seen = 0;
   int results_owed = 0;
   int n_drop       = 0;
   int n_empty      = 0;
   int n_range      = 0;
   int n_hits       = 0;

   // generator state
   int gen_held   = 0;
   int made       = 0;
   bit idle_on    = 1'b0;
   bit tail_part  = 1'b0;

   // driver state
   word_slot_type slot;
   bit            slot_ready = 1'b0;
   int            idle_left  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic spsel_pkg::rsp_type apply_word(spsel_pkg::req_type w);
      spsel_pkg::rsp_type r;
      int                 pos;
      longint unsigned    idx;
      r = '0;
      case (w.cmd)
         spsel_pkg::CMD_ADD: begin
            if (w.keep) begin
               if (held_n >= CAPACITY) begin
                  r.status = spsel_pkg::ST_FULL;
                  n_drop++;
               end else begin
                  // shift larger entries up; equal ones stay below the new sample
                  pos = held_n;
                  while (pos > 0 && sorted_vals[pos-1] > $signed(w.sample)) begin
                     sorted_vals[pos] = sorted_vals[pos-1];
                     pos--;
                  end
                  sorted_vals[pos] = $signed(w.sample);
                  held_n++;
               end
            end
         end
         spsel_pkg::CMD_PCT: begin
            if (held_n == 0) begin
               r.status = spsel_pkg::ST_EMPTY;
               n_empty++;
            end else if (w.percent > spsel_pkg::PCT_FULL_SCALE) begin
               r.status = spsel_pkg::ST_RANGE;
               n_range++;
            end else begin
               idx = (longint'(held_n - 1) * longint'(w.percent)) /
                     spsel_pkg::PCT_FULL_SCALE;
               r.result_value = sorted_vals[idx];
               n_hits++;
            end
         end
         spsel_pkg::CMD_MED: begin
            if (held_n == 0) begin
               r.status = spsel_pkg::ST_EMPTY;
               n_empty++;
            end else begin
               r.result_value = sorted_vals[held_n/2];
               n_hits++;
            end
         end
         default: held_n = 0;
      endcase
      r.held_count = 9'(held_n);
      return r;
   endfunction

   task automatic queue_word(input logic [1:0] cmd, input logic [31:0] smp, input logic kp,
                             input logic [13:0] pct, input logic hold);
      word_slot_type s;
      s.req.cmd     = cmd;
      s.req.sample  = smp;
      s.req.keep    = kp;
      s.req.percent = pct;
      s.drain       = hold && !tail_part;
      s.gap         = (idle_on && !tail_part && $urandom_range(0, 3) == 0) ?
                      3'($urandom_range(1, 4)) : 3'd0;
      word_q.push_back(s);
      if (cmd == spsel_pkg::CMD_ADD && kp && gen_held < CAPACITY) gen_held++;
      if (cmd == spsel_pkg::CMD_CLR) gen_held = 0;
      made++;
   endtask

   function automatic logic [31:0] pick_sample(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 16)) - 8);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   function automatic logic [13:0] pick_percent();
      case ($urandom_range(0, 9))
         0: return 14'd0;
         1: return spsel_pkg::PCT_FULL_SCALE;
         2: return 14'($urandom_range(10001, 16383));
         3: return 14'd16383;
         default: return 14'($urandom_range(0, 10000));
      endcase
   endfunction

   task automatic queue_query(input logic hold);
      if ($urandom_range(0, 2) != 0)
         queue_word(spsel_pkg::CMD_PCT, $urandom, 1'($urandom), pick_percent(), hold);
      else
         queue_word(spsel_pkg::CMD_MED, $urandom, 1'($urandom), 14'($urandom), hold);
   endtask

   task automatic build_stimulus();
      int mode;
      int fills;
      int op;
      int len;
      bit first;
      fills = 0;
      // directed: empty set, extremes, equal samples, range limits, clear
      queue_word(spsel_pkg::CMD_PCT, 32'd5, 1'b1, 14'd5000, 1'b0);
      queue_word(spsel_pkg::CMD_MED, 32'd0, 1'b0, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_CLR, 32'hFFFF_FFFF, 1'b1, 14'h3FFF, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'd123, 1'b0, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, 14'h3FFF, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'h8000_0000, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'h7FFF_FFFF, 1'b1, 14'h3FFF, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'h0000_0000, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'h0000_0000, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, spsel_pkg::PCT_FULL_SCALE, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, 14'd10001, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, 14'h3FFF, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, 14'd5000, 1'b0);
      queue_word(spsel_pkg::CMD_MED, 32'd0, 1'b0, 14'd0, 1'b1);
      queue_word(spsel_pkg::CMD_PCT, 32'hFFFF_FFFF, 1'b1, 14'd1, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 14'h3FFF, 1'b0);
      queue_word(spsel_pkg::CMD_CLR, 32'd0, 1'b0, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_MED, 32'd0, 1'b0, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_ADD, 32'd42, 1'b1, 14'd0, 1'b0);
      queue_word(spsel_pkg::CMD_PCT, 32'd0, 1'b0, spsel_pkg::PCT_FULL_SCALE, 1'b0);
      queue_word(spsel_pkg::CMD_MED, 32'd0, 1'b0, 14'd0, 1'b0);

      while (made < WORD_GOAL) begin
         idle_on   = $urandom_range(0, 3) != 0;
         tail_part = made > WORD_GOAL - TAIL_WORDS;
         mode      = $urandom_range(0, 2);
         if (fills == 0 || (fills < 3 && $urandom_range(0, 7) == 0)) begin
            // fill the store, then push past capacity
            fills++;
            while (gen_held < CAPACITY) begin
               if ($urandom_range(0, 9) == 0) queue_query(1'b0);
               else queue_word(spsel_pkg::CMD_ADD, pick_sample(mode), 1'b1,
                               14'($urandom), 1'b0);
            end
            repeat ($urandom_range(1, 6))
               queue_word(spsel_pkg::CMD_ADD, pick_sample(mode), 1'b1, 14'($urandom), 1'b0);
            repeat (4) queue_query(1'b0);
            if ($urandom_range(0, 1) == 0)
               queue_word(spsel_pkg::CMD_CLR, $urandom, 1'($urandom), 14'($urandom), 1'b0);
         end else begin
            len   = $urandom_range(5, 40);
            first = 1'b1;
            repeat (len) begin
               op = $urandom_range(0, 19);
               if (op < 11)
                  queue_word(spsel_pkg::CMD_ADD, pick_sample(mode), 1'b1, 14'($urandom),
                             first && $urandom_range(0, 2) == 0);
               else if (op < 13)
                  queue_word(spsel_pkg::CMD_ADD, pick_sample(mode), 1'b0, 14'($urandom),
                             1'b0);
               else if (op < 19)
                  queue_query(first && $urandom_range(0, 2) == 0);
               else
                  queue_word(spsel_pkg::CMD_CLR, $urandom, 1'($urandom), 14'($urandom),
                             1'b0);
               first = 1'b0;
            end
         end
      end
   endtask

   // driver: present the head word, honoring its idle lead-in and drain hold
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (!slot_ready && word_q.size() != 0) begin
            slot       = word_q.pop_front();
            idle_left  = slot.gap;
            slot_ready = 1'b1;
         end
         if (!slot_ready) begin
            start <= 1'b0;
         end else if (idle_left != 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (slot.drain && (start || results_owed != 0)) begin
            // hold until every outstanding result is back
            start <= 1'b0;
         end else begin
            start      <= 1'b1;
            req_data   <= slot.req;
            slot_ready = 1'b0;
         end
      end
   end

   // monitor: check the result word, then predict the word taken at this edge
   always @(posedge clock) begin
      spsel_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            results_seen++;
            if (answer_q.size() == 0) begin
               $error("result word with none expected: value %0d status %0d held %0d",
                      rsp_data.result_value, rsp_data.status, rsp_data.held_count);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value expected %0d, got %0d",
                         want.result_value, rsp_data.result_value);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.held_count !== want.held_count) begin
                  $error("held_count expected %0d, got %0d",
                         want.held_count, rsp_data.held_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            answer_q.push_back(apply_word(req_data));
            words_in++;
         end
         results_owed <= answer_q.size();
      end
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (word_q.size() != 0 || slot_ready || start || answer_q.size() != 0)
         @(negedge clock);
      // let a full-length insert pass to catch stray results
      repeat (CAPACITY + 40) @(negedge clock);
      if (answer_q.size() != 0) begin
         $error("%0d expected result words never arrived", answer_q.size());
         fail_count++;
      end
      $display("Sent %0d words, checked %0d results: %0d selections, %0d empty-set queries,",
               words_in, results_seen, n_hits, n_empty);
      $display("%0d out-of-range percentiles, %0d samples dropped on a full store.",
               n_range, n_drop);
      if (fail_count == 0)
         $display("sorted_percentile_selector test passed");
      else
         $display("sorted_percentile_selector test failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("sorted_percentile_selector test failed");
      $finish;
   end

endmodule
